>>> hw/rtl/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// Compiling with NO_ASSERTIONS defined removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

>>> hw/rtl/ald_pkg.sv
package ald_pkg;

   // Number of ASCII decimal digits in the length field.
   localparam int LENGTH_DIGITS = 14;
   // Header position counts the separator plus every digit.
   localparam int HDR_POS_W     = $clog2(LENGTH_DIGITS + 1);

   localparam int SYNC_LEN      = 5;
   localparam int SYNC_CNT_W    = $clog2(SYNC_LEN + 1);

   localparam int LEN_W         = 32;
   localparam int BYTE_W        = 8;

   localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

   typedef enum logic [1:0] {
      PHASE_HUNT    = 2'd0,
      PHASE_HEADER  = 2'd1,
      PHASE_PAYLOAD = 2'd2
   } phase_type;

   // Byte held in the input register.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data_byte;
   } item_type;

   // One result as produced by the core.
   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic              last_of_frame;
      logic              empty_frame;
   } result_type;

   // Sync word characters, in order of arrival.
   function automatic logic [BYTE_W-1:0] sync_char(input logic [SYNC_CNT_W-1:0] idx);
      logic [BYTE_W-1:0] ch;
      case (idx)
         3'd0:    ch = 8'h49;
         3'd1:    ch = 8'h44;
         3'd2:    ch = 8'h4F;
         3'd3:    ch = 8'h4F;
         3'd4:    ch = 8'h52;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

>>> hw/rtl/ald_if.sv
interface ald_req_if;
   import ald_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface ald_rsp_if;
   import ald_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] payload_byte;
   logic              last_of_frame;
   logic              empty_frame;

   modport source (output valid, output payload_byte, output last_of_frame,
                   output empty_frame, input ready);
   modport sink   (input valid, input payload_byte, input last_of_frame,
                   input empty_frame, output ready);
endinterface

>>> hw/rtl/ascii_length_prefixed_deframer.sv
// Deframer for a received byte stream: hunts for a five-byte ASCII sync word,
// skips one unchecked separator byte, reads a fixed count of ASCII decimal
// length digits and then passes that many payload bytes out, flagging the
// last one. A length of zero, a non-digit in the length field or a length
// that does not fit 32 bits gives one empty-frame transaction (last and
// empty set, byte zero). Bytes outside frames give no transaction. One byte
// is taken every clock cycle for as long as the result side keeps up. An
// accepted byte is held in the input register; once the result register has
// room, its result is loaded into the result register and is offered from
// then on. A byte that gives no result still waits in the input register
// while the result register is full and not being drained. The per-byte path
// is the decimal multiply-accumulate of the length field (a 36-bit add and
// compare).
`include "assert_macros.svh"

module ascii_length_prefixed_deframer
   import ald_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ald_req_if.sink   req_if,
   ald_rsp_if.source rsp_if
);

   item_type   item;        // byte waiting in the input register
   logic       advance;     // input byte consumed by the core this cycle
   logic       res_valid;   // core produces a result for that byte
   result_type res;
   logic       out_free;    // result register can take a new transaction
   logic       in_stall;    // input byte held back this cycle
   logic       empty_bad;   // empty-frame fields not in their fixed form

   // A byte moves on only when the result register has room, whether or not
   // it yields a result, so the core state never runs ahead of the output.
   assign advance = item.valid && out_free;

   ald_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .advance (advance),
      .item    (item)
   );

   // sync hunt, header parse and payload count
   ald_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .advance   (advance),
      .res_valid (res_valid),
      .res       (res)
   );

   ald_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .load   (advance && res_valid),
      .res    (res),
      .free   (out_free),
      .rsp_if (rsp_if)
   );

   assign in_stall  = item.valid && !advance;
   assign empty_bad = rsp_if.empty_frame
                    && (!rsp_if.last_of_frame || (rsp_if.payload_byte != '0));

   // accepted byte lands in the input register
   `ASSERT_PROP(in_capture_a, clock, reset, req_if.valid && req_if.ready |=> item.valid)

   // a stalled input byte is neither lost nor changed
   `ASSERT_PROP(in_hold_a, clock, reset, in_stall |=> item.valid && $stable(item.data_byte))

   // an empty-frame transaction always closes the frame and carries no byte
   `ASSERT_NEVER(empty_fmt_a, clock, reset, rsp_if.valid && empty_bad)

endmodule

>>> hw/rtl/ald_in_stage.sv
module ald_in_stage
   import ald_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ald_req_if.sink    req_if,
   input  logic       advance,
   output item_type   item
);

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              accept;

   // Register is free when empty or being drained this cycle.
   assign req_if.ready = !valid_ff || advance;
   assign accept       = req_if.valid && req_if.ready;
   assign valid_in     = accept || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_if.data_byte;
      end
   end

   assign item.valid     = valid_ff;
   assign item.data_byte = byte_ff;

endmodule

>>> hw/rtl/ald_core.sv
module ald_core
   import ald_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  item_type   item,
   input  logic       advance,
   output logic       res_valid,
   output result_type res
);

   localparam logic [HDR_POS_W-1:0] HDR_LAST = HDR_POS_W'(LENGTH_DIGITS);

   phase_type              phase_ff, phase_in;
   logic [SYNC_CNT_W-1:0]  sync_ff, sync_in;
   logic [HDR_POS_W-1:0]   hdr_pos_ff, hdr_pos_in;
   logic [LEN_W-1:0]       acc_ff, acc_in;
   logic                   invalid_ff, invalid_in;
   logic [LEN_W-1:0]       remain_ff, remain_in;

   logic                   digit_ok;
   logic [LEN_W+3:0]       prod;
   logic                   ovf;
   logic                   is_digit_pos;
   logic [LEN_W-1:0]       acc_step;
   logic                   inv_step;
   logic [SYNC_CNT_W-1:0]  sync_cur;
   logic [SYNC_CNT_W-1:0]  sync_next;

   // acc*10 + digit, wide enough to see a carry past 32 bits
   assign digit_ok = (item.data_byte >= ASCII_ZERO) && (item.data_byte <= ASCII_NINE);
   assign prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
               + (LEN_W+4)'(item.data_byte[3:0]);
   assign ovf  = |prod[LEN_W+3:LEN_W];

   // separator at position zero is skipped unchecked
   assign is_digit_pos = (hdr_pos_ff != '0);
   assign acc_step = (is_digit_pos && digit_ok && !ovf) ? prod[LEN_W-1:0] : acc_ff;
   assign inv_step = invalid_ff || (is_digit_pos && (!digit_ok || ovf));

   // sync hunt: a mismatch may still start a new match
   assign sync_cur  = (sync_ff >= SYNC_CNT_W'(SYNC_LEN)) ? '0 : sync_ff;
   assign sync_next = (item.data_byte == sync_char(sync_cur)) ? sync_cur + 1'b1 :
                      (item.data_byte == sync_char('0))       ? SYNC_CNT_W'(1) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_HUNT;
         sync_ff    <= '0;
         hdr_pos_ff <= '0;
         acc_ff     <= '0;
         invalid_ff <= 1'b0;
         remain_ff  <= '0;
      end else begin
         phase_ff   <= phase_in;
         sync_ff    <= sync_in;
         hdr_pos_ff <= hdr_pos_in;
         acc_ff     <= acc_in;
         invalid_ff <= invalid_in;
         remain_ff  <= remain_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      sync_in    = sync_ff;
      hdr_pos_in = hdr_pos_ff;
      acc_in     = acc_ff;
      invalid_in = invalid_ff;
      remain_in  = remain_ff;
      res_valid  = 1'b0;
      res        = '0;

      if (advance) begin
         unique case (phase_ff)
            PHASE_HEADER: begin
               acc_in     = acc_step;
               invalid_in = inv_step;
               if (hdr_pos_ff == HDR_LAST) begin
                  hdr_pos_in = '0;
                  sync_in    = '0;
                  acc_in     = '0;
                  if (inv_step || (acc_step == '0)) begin
                     phase_in          = PHASE_HUNT;
                     invalid_in        = 1'b0;
                     res_valid         = 1'b1;
                     res.last_of_frame = 1'b1;
                     res.empty_frame   = 1'b1;
                  end else begin
                     phase_in  = PHASE_PAYLOAD;
                     remain_in = acc_step;
                  end
               end else begin
                  hdr_pos_in = hdr_pos_ff + 1'b1;
               end
            end

            PHASE_PAYLOAD: begin
               res_valid        = 1'b1;
               res.payload_byte = item.data_byte;
               if (remain_ff != '0) begin
                  remain_in = remain_ff - 1'b1;
               end
               if (remain_ff <= LEN_W'(1)) begin
                  res.last_of_frame = 1'b1;
                  phase_in          = PHASE_HUNT;
                  sync_in           = '0;
               end
            end

            default: begin
               phase_in = PHASE_HUNT;
               if (sync_next == SYNC_CNT_W'(SYNC_LEN)) begin
                  sync_in    = '0;
                  phase_in   = PHASE_HEADER;
                  hdr_pos_in = '0;
                  acc_in     = '0;
                  invalid_in = 1'b0;
               end else begin
                  sync_in = sync_next;
               end
            end
         endcase
      end
   end

endmodule

>>> hw/rtl/ald_out_stage.sv
module ald_out_stage
   import ald_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type res,
   output logic       free,
   ald_rsp_if.source  rsp_if
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   assign free     = !valid_ff || rsp_if.ready;
   assign valid_in = load || (valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.payload_byte  = res_ff.payload_byte;
   assign rsp_if.last_of_frame = res_ff.last_of_frame;
   assign rsp_if.empty_frame   = res_ff.empty_frame;

endmodule

>>> bench/tb_ascii_length_prefixed_deframer.sv
`timescale 1ns / 1ps

module tb_ascii_length_prefixed_deframer;
   import ald_pkg::*;

   // Sync word bytes, first to arrive in the top byte.
   localparam logic [SYNC_LEN*BYTE_W-1:0] SYNC_WORD = 40'h49_44_4F_4F_52;
   // Largest length value that still fits the 32-bit length.
   localparam logic [63:0] LEN_MAX = 64'h0000_0000_FFFF_FFFF;
   // Cycles without any transaction before the run is declared hung.
   localparam int STALL_LIMIT = 2000;
   // Long receiver hold-off, so the pipeline fills and backs up into req.
   localparam int HOLD_CYCLES = 300;
   // Drain time after the last expected result (two register stages).
   localparam int DRAIN_CYCLES = 10;

   logic clock;
   logic reset;

   ald_req_if req_ch ();
   ald_rsp_if rsp_ch ();

   ascii_length_prefixed_deframer dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source)
   );

   // ---------------------------------------------------------------
   // Stimulus and expectation storage
   // ---------------------------------------------------------------
   logic [BYTE_W-1:0] rx_stream[$];          // bytes waiting to be offered
   result_type        expected_payload[$];   // predicted rsp transactions

   int bytes_total;     // bytes queued in all
   int bytes_taken;     // req transactions seen
   int framed_bytes;    // bytes that belong to frames (noise excluded)
   int fail_count;
   int cycle_count;
   int stall_cycles;

   // Predictor state, mirrors the deframer's own registers.
   phase_type              frame_phase;
   logic [SYNC_CNT_W-1:0]  sync_count;
   logic [HDR_POS_W-1:0]   hdr_count;
   logic [LEN_W-1:0]       len_value;
   logic                   len_bad;
   logic [LEN_W-1:0]       bytes_left;

   // Driver / receiver handshake bookkeeping.
   logic req_taken;     // req transaction at the last rising edge
   int   send_gap;
   int   recv_gap;
   int   hold_left;
   bit   hold_done;

   function automatic logic [BYTE_W-1:0] sync_at(input int idx);
      return SYNC_WORD[(SYNC_LEN - 1 - idx)*BYTE_W +: BYTE_W];
   endfunction

   // No idling in the last stretch of the stream and in periodic windows.
   function automatic bit is_calm();
      return (rx_stream.size() < 200) || (cycle_count[9:8] == 2'b11);
   endfunction

   // ---------------------------------------------------------------
   // Predictor: one received byte in, zero or one result out
   // ---------------------------------------------------------------
   task automatic deframe_byte(input logic [BYTE_W-1:0] b);
      logic [63:0] grown;
      result_type  r;
      case (frame_phase)
         PHASE_HEADER: begin
            // first header byte is the separator, never checked
            if (hdr_count != 0) begin
               if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
                  grown = {32'd0, len_value} * 64'd10 + 64'(b - ASCII_ZERO);
                  if (grown > LEN_MAX)
                     len_bad = 1'b1;
                  else
                     len_value = grown[LEN_W-1:0];
               end else begin
                  len_bad = 1'b1;
               end
            end
            hdr_count = hdr_count + 1'b1;
            if (hdr_count >= LENGTH_DIGITS + 1) begin
               hdr_count  = '0;
               sync_count = '0;
               if (len_bad || len_value == 0) begin
                  // bad or zero length: one empty-frame transaction
                  frame_phase     = PHASE_HUNT;
                  len_value       = '0;
                  len_bad         = 1'b0;
                  r.payload_byte  = '0;
                  r.last_of_frame = 1'b1;
                  r.empty_frame   = 1'b1;
                  expected_payload.push_back(r);
               end else begin
                  bytes_left  = len_value;
                  len_value   = '0;
                  frame_phase = PHASE_PAYLOAD;
               end
            end
         end
         PHASE_PAYLOAD: begin
            if (bytes_left != 0)
               bytes_left = bytes_left - 1'b1;
            r.payload_byte  = b;
            r.empty_frame   = 1'b0;
            r.last_of_frame = (bytes_left == 0);
            if (bytes_left == 0) begin
               frame_phase = PHASE_HUNT;
               sync_count  = '0;
            end
            expected_payload.push_back(r);
         end
         default: begin
            // hunting; a mismatch that is itself the first sync char restarts at one
            frame_phase = PHASE_HUNT;
            if (sync_count >= SYNC_LEN)
               sync_count = '0;
            if (b == sync_at(sync_count))
               sync_count = sync_count + 1'b1;
            else
               sync_count = (b == sync_at(0)) ? SYNC_CNT_W'(1) : '0;
            if (sync_count == SYNC_LEN) begin
               sync_count  = '0;
               frame_phase = PHASE_HEADER;
               hdr_count   = '0;
               len_value   = '0;
               len_bad     = 1'b0;
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------
   // Stream builders
   // ---------------------------------------------------------------
   // Bytes between frames; optionally starts with a broken sync prefix.
   task automatic queue_noise(input int count, input bit broken_sync);
      int cut;
      if (broken_sync) begin
         cut = $urandom_range(1, SYNC_LEN - 1);
         for (int i = 0; i < cut; i++)
            rx_stream.push_back(sync_at(i));
      end
      for (int i = 0; i < count; i++)
         rx_stream.push_back(BYTE_W'($urandom_range(0, 255)));
   endtask

   // Full frame: sync, separator, length digits, payload.
   // bad_pos >= 0 replaces that length digit with bad_char.
   // Payload is cut to max_body bytes (only the huge-length tail frame needs that).
   task automatic queue_frame(input logic [BYTE_W-1:0] sep, input logic [63:0] len_field,
                              input int bad_pos, input logic [BYTE_W-1:0] bad_char,
                              input int max_body, input bit nest_sync);
      logic [BYTE_W-1:0] digits[LENGTH_DIGITS];
      logic [63:0]       v;
      int                body;
      v = len_field;
      for (int i = LENGTH_DIGITS - 1; i >= 0; i--) begin
         digits[i] = ASCII_ZERO + BYTE_W'(v % 64'd10);
         v = v / 64'd10;
      end
      if (bad_pos >= 0)
         digits[bad_pos] = bad_char;
      if (bad_pos >= 0 || len_field == 0 || len_field > LEN_MAX)
         body = 0;
      else if (len_field > 64'(max_body))
         body = max_body;
      else
         body = int'(len_field);
      for (int i = 0; i < SYNC_LEN; i++)
         rx_stream.push_back(sync_at(i));
      rx_stream.push_back(sep);
      for (int i = 0; i < LENGTH_DIGITS; i++)
         rx_stream.push_back(digits[i]);
      for (int i = 0; i < body; i++) begin
         // a sync word inside the payload is plain data
         if (nest_sync && i < SYNC_LEN)
            rx_stream.push_back(sync_at(i));
         else
            rx_stream.push_back(BYTE_W'($urandom_range(0, 255)));
      end
      framed_bytes += SYNC_LEN + 1 + LENGTH_DIGITS + body;
   endtask

   function automatic logic [BYTE_W-1:0] non_digit();
      logic [BYTE_W-1:0] c;
      c = BYTE_W'($urandom_range(0, 255));
      while (c >= ASCII_ZERO && c <= ASCII_NINE)
         c = BYTE_W'($urandom_range(0, 255));
      return c;
   endfunction

   // ---------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // Main sequence: build stream, reset, wait for drain, report
   // ---------------------------------------------------------------
   initial begin
      int          kind;
      logic [63:0] len;
      reset         = 1'b1;
      frame_phase   = PHASE_HUNT;
      sync_count    = '0;
      hdr_count     = '0;
      len_value     = '0;
      len_bad       = 1'b0;
      bytes_left    = '0;
      framed_bytes  = 0;

      // Directed part.
      // noise, then partial sync broken by an extra 'I' ahead of the real sync
      rx_stream.push_back(8'h00);
      rx_stream.push_back(8'hFF);
      rx_stream.push_back(sync_at(0));
      rx_stream.push_back(sync_at(1));
      rx_stream.push_back(sync_at(2));
      rx_stream.push_back(sync_at(0));
      queue_frame(8'h00, 64'd1, -1, 8'h00, 64, 1'b0);
      queue_frame(8'hFF, 64'd0, -1, 8'h00, 64, 1'b0);            // zero length
      queue_frame(sync_at(0), 64'd2, -1, 8'h00, 64, 1'b0);       // sync char as separator
      queue_frame(8'h20, 64'd5, LENGTH_DIGITS - 1, 8'h2F, 64, 1'b0); // char below '0'
      queue_frame(8'h2D, 64'd7, 0, 8'h3A, 64, 1'b0);             // char above '9'
      queue_frame(8'h7F, LEN_MAX + 1, -1, 8'h00, 64, 1'b0);      // just past 32 bits
      queue_frame(8'h80, 64'd99_999_999_999_999, -1, 8'h00, 64, 1'b0);
      queue_frame(8'h0A, 64'd9, -1, 8'h00, 64, 1'b1);            // sync word in payload

      // Random part: mostly well-formed frames with random content.
      while (framed_bytes < 880) begin
         queue_noise($urandom_range(0, 4), $urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0)
            queue_noise($urandom_range(5, 30), 1'b0);
         kind = $urandom_range(0, 19);
         if (kind == 0)
            len = 64'd0;
         else if (kind == 3)
            len = LEN_MAX + 64'd1 + {$urandom_range(0, 16000), $urandom};
         else if ($urandom_range(0, 3) == 0)
            len = 64'($urandom_range(1, 3));
         else
            len = 64'($urandom_range(1, 24));
         queue_frame(BYTE_W'($urandom_range(0, 255)), len,
                     (kind == 1 || kind == 2) ? $urandom_range(0, LENGTH_DIGITS - 1) : -1,
                     non_digit(), 64, $urandom_range(0, 7) == 0);
      end
      // largest valid length; the stream ends inside its payload
      queue_frame(BYTE_W'($urandom_range(0, 255)), LEN_MAX, -1, 8'h00, 40, 1'b0);
      bytes_total = rx_stream.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (bytes_taken < bytes_total || expected_payload.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------
   // Driver: req side, changes on the falling edge
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.data_byte <= '0;
         send_gap         <= 0;
      end else if (!req_ch.valid || req_taken) begin
         // previous byte gone (or none offered): pick what to do next
         if (send_gap > 0) begin
            req_ch.valid <= 1'b0;
            send_gap     <= send_gap - 1;
         end else if (!is_calm() && hold_left == 0 && $urandom_range(0, 19) == 0) begin
            req_ch.valid <= 1'b0;
            send_gap     <= $urandom_range(0, 13);
         end else if (rx_stream.size() != 0) begin
            req_ch.valid     <= 1'b1;
            req_ch.data_byte <= rx_stream.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Receiver: rsp ready, random bursts plus one long hold-off
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap     <= 0;
         hold_left    <= 0;
         hold_done    <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!hold_done && bytes_taken >= 400) begin
         rsp_ch.ready <= 1'b0;
         hold_done    <= 1'b1;
         hold_left    <= HOLD_CYCLES - 1;
      end else if (recv_gap > 0) begin
         rsp_ch.ready <= 1'b0;
         recv_gap     <= recv_gap - 1;
      end else if (!is_calm() && $urandom_range(0, 15) == 0) begin
         rsp_ch.ready <= 1'b0;
         recv_gap     <= $urandom_range(0, 13);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Monitor: both handshakes sampled on the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      int         errs;
      if (reset) begin
         req_taken   <= 1'b0;
         cycle_count <= 0;
         bytes_taken <= 0;
         fail_count  <= 0;
      end else begin
         errs = 0;
         cycle_count <= cycle_count + 1;
         req_taken   <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            deframe_byte(req_ch.data_byte);
            bytes_taken <= bytes_taken + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_payload.size() == 0) begin
               $error("unexpected transaction: payload_byte %h last %b empty %b",
                      rsp_ch.payload_byte, rsp_ch.last_of_frame, rsp_ch.empty_frame);
               errs++;
            end else begin
               want = expected_payload.pop_front();
               if (rsp_ch.payload_byte !== want.payload_byte) begin
                  $error("payload_byte: expected %h, got %h",
                         want.payload_byte, rsp_ch.payload_byte);
                  errs++;
               end
               if (rsp_ch.last_of_frame !== want.last_of_frame) begin
                  $error("last_of_frame: expected %b, got %b",
                         want.last_of_frame, rsp_ch.last_of_frame);
                  errs++;
               end
               if (rsp_ch.empty_frame !== want.empty_frame) begin
                  $error("empty_frame: expected %b, got %b",
                         want.empty_frame, rsp_ch.empty_frame);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

   // ---------------------------------------------------------------
   // Watchdog: cycles in a row with no transaction on either side
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
